@@ rtl/lssfr_pkg.sv @@
// shared types and constants for the led strip split frame renderer
`default_nettype none

package lssfr_pkg;

  // fixed widths of the datapath
  localparam int IDX_W   = 6;   // pixel index
  localparam int POS_W   = 15;  // boundary position, Q7.8
  localparam int RN_W    = 14;  // ratio times led count
  localparam int CLR_W   = 24;  // packed color
  localparam int SF_W    = 9;   // smooth factor
  localparam int PER_W   = 16;  // blink period
  localparam int MS_W    = 32;  // timestamp
  localparam int CIDX_W  = 2;   // config register index

  // frame phase codes
  localparam logic [2:0] PH_WAIT = 3'd0;
  localparam logic [2:0] PH_PLAY = 3'd1;
  localparam logic [2:0] PH_WIN0 = 3'd2;
  localparam logic [2:0] PH_WIN1 = 3'd3;
  localparam logic [2:0] PH_TIE  = 3'd4;

  // config register indexes
  localparam logic [CIDX_W-1:0] CFG_TEAM0  = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TEAM1  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_SMOOTH = 2'd2;
  localparam logic [CIDX_W-1:0] CFG_BLINK  = 2'd3;

  // config reset values
  localparam logic [CLR_W-1:0] TEAM0_RST  = 24'h0000FF;
  localparam logic [CLR_W-1:0] TEAM1_RST  = 24'hFF8000;
  localparam logic [SF_W-1:0]  SMOOTH_RST = 9'd15;
  localparam logic [PER_W-1:0] BLINK_RST  = 16'd500;

  // waiting dim factor, c*61/256
  localparam logic [7:0] DIM_MUL = 8'd61;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TGT_MUL,
    ST_TGT_DIV,
    ST_TGT_FIX,
    ST_STEP,
    ST_POS,
    ST_BLINK,
    ST_EMIT
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic ld_in;
    logic tgt_mul;
    logic tgt_div;
    logic tgt_fix;
    logic step_mul;
    logic pos_upd;
    logic blink_upd;
    logic px_load;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic out_free;
    logic px_last;
  } sts_t;

  // dim one color component
  function automatic logic [7:0] dim8(input logic [7:0] c);
    logic [15:0] prod;
    prod = {8'd0, c} * {8'd0, DIM_MUL};
    return prod[15:8];
  endfunction

  // dim a packed color
  function automatic logic [CLR_W-1:0] dim_rgb(input logic [CLR_W-1:0] rgb);
    return {dim8(rgb[23:16]), dim8(rgb[15:8]), dim8(rgb[7:0])};
  endfunction

endpackage

`default_nettype wire

@@ rtl/lssfr_ctrl.sv @@
// frame sequencer state machine for the split frame renderer
`default_nettype none

module lssfr_ctrl (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  input  wire logic [2:0]    in_phase,
  input  wire lssfr_pkg::sts_t sts,
  output lssfr_pkg::cmd_t    cmd,
  output logic               in_ready
);
  import lssfr_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (in_phase == PH_PLAY) begin
            state_nxt = ST_TGT_MUL;
          end else if (in_phase == PH_WIN0 || in_phase == PH_WIN1 ||
                       in_phase == PH_TIE) begin
            state_nxt = ST_BLINK;
          end else begin
            state_nxt = ST_EMIT;
          end
        end
      end
      ST_TGT_MUL: state_nxt = ST_TGT_DIV;
      ST_TGT_DIV: state_nxt = ST_TGT_FIX;
      ST_TGT_FIX: state_nxt = ST_STEP;
      ST_STEP:    state_nxt = ST_POS;
      ST_POS:     state_nxt = ST_EMIT;
      ST_BLINK:   state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (sts.out_free && sts.px_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default:    state_nxt = ST_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.ld_in  = in_valid;
      end
      ST_TGT_MUL: cmd.tgt_mul   = 1'b1;
      ST_TGT_DIV: cmd.tgt_div   = 1'b1;
      ST_TGT_FIX: cmd.tgt_fix   = 1'b1;
      ST_STEP:    cmd.step_mul  = 1'b1;
      ST_POS:     cmd.pos_upd   = 1'b1;
      ST_BLINK:   cmd.blink_upd = 1'b1;
      ST_EMIT:    cmd.px_load   = sts.out_free;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/lssfr_dp.sv @@
// datapath: config registers, boundary glide, blink timer, pixel output register
`default_nettype none

module lssfr_dp #(
  parameter int LED_COUNT = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire lssfr_pkg::cmd_t               cmd,
  output lssfr_pkg::sts_t                    sts,
  input  wire logic                          cfg_we,
  input  wire logic [lssfr_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [lssfr_pkg::CLR_W-1:0]   cfg_wdata,
  input  wire logic [7:0]                    in_ratio,
  input  wire logic [2:0]                    in_phase,
  input  wire logic [lssfr_pkg::MS_W-1:0]    in_now_ms,
  input  wire logic [7:0]                    in_spark_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lssfr_pkg::IDX_W-1:0]        out_pixel_index,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_last_pixel
);
  import lssfr_pkg::*;

  localparam int FULL = LED_COUNT * 256;
  localparam logic [POS_W-1:0] POS_FULL = POS_W'(FULL);
  localparam logic [POS_W-1:0] POS_MID  = POS_W'(LED_COUNT * 128);
  localparam logic [POS_W-1:0] POS_END  = POS_W'(FULL - 384);
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(LED_COUNT - 1);
  localparam logic [IDX_W-1:0] IDX_HALF = IDX_W'(LED_COUNT / 2);

  // config registers
  logic [CLR_W-1:0] team0_r, team1_r;
  logic [SF_W-1:0]  smooth_r;
  logic [PER_W-1:0] period_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      team0_r  <= TEAM0_RST;
      team1_r  <= TEAM1_RST;
      smooth_r <= SMOOTH_RST;
      period_r <= BLINK_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TEAM0:  team0_r  <= cfg_wdata;
        CFG_TEAM1:  team1_r  <= cfg_wdata;
        CFG_SMOOTH: smooth_r <= cfg_wdata[SF_W-1:0];
        CFG_BLINK:  period_r <= cfg_wdata[PER_W-1:0];
        default: ;
      endcase
    end
  end

  // captured frame request
  logic [7:0]      ratio_r, spark_r;
  logic [2:0]      phase_r;
  logic [MS_W-1:0] now_r;

  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      ratio_r <= in_ratio;
      phase_r <= in_phase;
      now_r   <= in_now_ms;
      spark_r <= in_spark_level;
    end
  end

  // target = round(ratio*N*256/255), by reciprocal 257/65536 and one correction
  logic [RN_W-1:0]  rn_r;
  logic [21:0]      x_val;
  logic [30:0]      x_mul;
  logic [POS_W-1:0] q0_r, tgt_r, tgt_nxt;
  logic [22:0]      q0_255, rem;

  assign x_val  = {rn_r, 8'd127};
  assign x_mul  = 31'({x_val, 8'd0}) + 31'(x_val);
  assign q0_255 = 23'({q0_r, 8'd0}) - 23'(q0_r);
  assign rem    = 23'(x_val) - q0_255;
  assign tgt_nxt = (rem >= 23'd255) ? q0_r + POS_W'(1) : q0_r;

  always_ff @(posedge clk) begin
    if (cmd.tgt_mul) begin
      rn_r <= RN_W'(ratio_r * LED_COUNT);
    end
    if (cmd.tgt_div) begin
      q0_r <= x_mul[30:16];
    end
    if (cmd.tgt_fix) begin
      tgt_r <= tgt_nxt;
    end
  end

  // glide step, magnitude times factor rounded half away from zero
  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [POS_W:0]   diff;
  logic [POS_W:0]   diff_abs;
  logic [SF_W-1:0]  sf_eff;
  logic [23:0]      step_prod;
  logic [POS_W-1:0] q_r;
  logic             neg_r;
  logic [POS_W+1:0] pos_sum;

  assign diff      = {1'b0, tgt_r} - {1'b0, pos_r};
  assign diff_abs  = diff[POS_W] ? (~diff + (POS_W+1)'(1)) : diff;
  assign sf_eff    = smooth_r[SF_W-1] ? 9'd256 : smooth_r;
  assign step_prod = 24'(diff_abs[POS_W-1:0]) * 24'(sf_eff) + 24'd128;

  always_ff @(posedge clk) begin
    if (cmd.step_mul) begin
      q_r   <= step_prod[22:8];
      neg_r <= diff[POS_W];
    end
  end

  // boundary update with clamp to the strip
  always_comb begin
    if (neg_r) begin
      pos_sum = {2'b00, pos_r} - {2'b00, q_r};
    end else begin
      pos_sum = {2'b00, pos_r} + {2'b00, q_r};
    end
    if (pos_sum[POS_W+1]) begin
      pos_nxt = '0;
    end else if (pos_sum > {2'b00, POS_FULL}) begin
      pos_nxt = POS_FULL;
    end else begin
      pos_nxt = pos_sum[POS_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_MID;
    end else if (cmd.pos_upd) begin
      pos_r <= pos_nxt;
    end
  end

  // blink timer
  logic            blink_r;
  logic [MS_W-1:0] blink_stamp_r;
  logic [MS_W-1:0] elapsed;

  assign elapsed = now_r - blink_stamp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_r       <= 1'b1;
      blink_stamp_r <= '0;
    end else if (cmd.blink_upd && elapsed >= MS_W'(period_r)) begin
      blink_r       <= ~blink_r;
      blink_stamp_r <= now_r;
    end
  end

  // color of the pixel at the counter
  logic [IDX_W-1:0] px_cnt_r;
  logic [POS_W:0]   px_pos, pos_ext;
  logic             near_start, at_end;
  logic [CLR_W-1:0] grey, px_color;

  assign px_pos     = (POS_W+1)'({px_cnt_r, 8'd0});
  assign pos_ext    = {1'b0, pos_r};
  assign near_start = pos_r < POS_W'(128);
  assign at_end     = pos_r > POS_END;
  assign grey       = {spark_r, spark_r, spark_r};

  always_comb begin
    case (phase_r)
      PH_PLAY: begin
        if (px_pos + (POS_W+1)'(128) < pos_ext) begin
          px_color = team0_r;
        end else if (px_pos > pos_ext + (POS_W+1)'(128)) begin
          px_color = team1_r;
        end else if (near_start) begin
          px_color = team1_r;
        end else if (at_end) begin
          px_color = team0_r;
        end else begin
          px_color = grey;
        end
      end
      PH_WIN0: px_color = blink_r ? team0_r : '0;
      PH_WIN1: px_color = blink_r ? team1_r : '0;
      PH_TIE:  px_color = blink_r ? team0_r : team1_r;
      default: px_color = dim_rgb((px_cnt_r < IDX_HALF) ? team0_r : team1_r);
    endcase
  end

  // pixel counter
  always_ff @(posedge clk) begin
    if (cmd.ld_in) begin
      px_cnt_r <= '0;
    end else if (cmd.px_load) begin
      px_cnt_r <= px_cnt_r + IDX_W'(1);
    end
  end

  // output word register
  logic             out_valid_r;
  logic [IDX_W-1:0] out_idx_r;
  logic [CLR_W-1:0] out_rgb_r;
  logic             out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.px_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.px_load) begin
      out_idx_r  <= px_cnt_r;
      out_rgb_r  <= px_color;
      out_last_r <= (px_cnt_r == IDX_LAST);
    end
  end

  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.px_last  = (px_cnt_r == IDX_LAST);

  assign out_valid       = out_valid_r;
  assign out_pixel_index = out_idx_r;
  assign out_red         = out_rgb_r[23:16];
  assign out_green       = out_rgb_r[15:8];
  assign out_blue        = out_rgb_r[7:0];
  assign out_last_pixel  = out_last_r;

endmodule

`default_nettype wire

@@ rtl/led_strip_split_frame_renderer_unit.sv @@
// top level of the led strip split frame renderer
//
// Takes one frame request per input word (ratio, phase, now_ms, spark_level)
// and answers with LED_COUNT output words, one color per LED from index 0
// upward; the last word carries out_last_pixel. Both channels use
// valid/ready. Config registers (team colors, smooth factor, blink period)
// are written through cfg_we/cfg_index/cfg_wdata.
//
// The playing phase runs target multiply, reciprocal divide by 255,
// correction, glide multiply and boundary clamp before pixel load; win and
// tie phases run the blink timer update first; other phases load directly.
// Pixels then leave at one per cycle through the single output register
// while out_ready is high; in_ready is high only between frames, while the
// final pixel may still sit in the output register. A stall on out_ready
// holds the output word and pauses the pixel counter. Reset (rst_n low,
// synchronous) restores config defaults, centers the boundary, sets the
// blink on and clears the blink timestamp. Config registers are to be
// written only while the block is idle; the block does not enforce this.
`default_nettype none

module led_strip_split_frame_renderer_unit #(
  parameter int LED_COUNT = 32
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [7:0]                    in_ratio,
  input  wire logic [2:0]                    in_phase,
  input  wire logic [lssfr_pkg::MS_W-1:0]    in_now_ms,
  input  wire logic [7:0]                    in_spark_level,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic [lssfr_pkg::IDX_W-1:0]        out_pixel_index,
  output logic [7:0]                         out_red,
  output logic [7:0]                         out_green,
  output logic [7:0]                         out_blue,
  output logic                               out_last_pixel,
  input  wire logic                          cfg_we,
  input  wire logic [lssfr_pkg::CIDX_W-1:0]  cfg_index,
  input  wire logic [lssfr_pkg::CLR_W-1:0]   cfg_wdata
);
  import lssfr_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // sequencer
  lssfr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_phase (in_phase),
    .sts      (sts),
    .cmd      (cmd),
    .in_ready (in_ready)
  );

  // datapath
  lssfr_dp #(
    .LED_COUNT (LED_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_ratio        (in_ratio),
    .in_phase        (in_phase),
    .in_now_ms       (in_now_ms),
    .in_spark_level  (in_spark_level),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_index (out_pixel_index),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue),
    .out_last_pixel  (out_last_pixel)
  );

  // one frame at a time: a request is never taken back to back
  a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while a frame is in progress");

  // a new frame starts only after every earlier pixel but the last has gone
  a_frame_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !(out_valid && !out_last_pixel))
    else $error("new frame accepted with pixels still pending");

  // the last flag marks the final led
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_pixel |-> out_pixel_index == IDX_W'(LED_COUNT - 1))
    else $error("last pixel flag on wrong index");

endmodule

`default_nettype wire
